/* hw/rtl/itrb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itrb_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_RECORD     = 2'd0,
    OP_READ_AGE   = 2'd1,
    OP_READ_TRANS = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  localparam int unsigned CountW = 9;

  // one stored trace record
  typedef struct packed {
    logic [7:0]  version;
    logic [15:0] segment;
    logic [31:0] position;
  } rec_t;

  // input item
  typedef struct packed {
    op_e         opcode;
    logic [7:0]  in_version;
    logic [15:0] in_segment;
    logic [31:0] in_position;
    logic [7:0]  age_index;
  } in_t;

  // result item
  typedef struct packed {
    logic              ok;
    logic [CountW-1:0] entry_count;
    logic [7:0]        out_version;
    logic [15:0]       out_segment;
    logic [31:0]       out_position;
    logic [7:0]        prev_version;
    logic [15:0]       prev_segment;
    logic [31:0]       prev_position;
  } out_t;

  // store port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // occupancy status
  typedef struct packed {
    logic [CountW-1:0] capacity;
    logic [CountW-1:0] held;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/instruction_trace_ring_buffer.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   valid        stall         payload
// -------   -----------  ------------  -------------
// input     in_valid_i   in_stall_o    in_data_i
// output    out_valid_o  out_stall_i   out_data_o
// config    cfg_we_i     (none)        cfg_wdata_i
//
// One item per cycle unless stalled; its registered result shows in the cycle after.
// Each item is one pass through the control logic and at most one access of the store port.
// Reset clears capacity, pointers, count and the transition; store contents stay undefined.
// The input stalls only while a result is held and the output is stalled.

module instruction_trace_ring_buffer import itrb_pkg::*; #(
  parameter int unsigned MAX_DEPTH        = 256,
  parameter int unsigned EXPECTED_VERSION = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_t                   out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(MAX_DEPTH);

  logic             accept;
  out_t             res;
  logic             use_mem;
  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] wr_addr;
  rec_t             wr_data;
  logic [AddrW-1:0] rd_addr;
  rec_t             rd_data;
  stat_t            stat;

  logic             out_valid_q;
  out_t             out_q;
  logic             sel_mem_q;

  // input transfer
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  itrb_ctrl #(
    .MAX_DEPTH        (MAX_DEPTH),
    .EXPECTED_VERSION (EXPECTED_VERSION)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res),
    .use_mem_o   (use_mem),
    .mem_ctl_o   (mem_ctl),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .stat_o      (stat)
  );

  itrb_store #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q     <= res;
      sel_mem_q <= use_mem;
    end
  end

  // read by age takes its record from the store read register
  always_comb begin
    out_data_o = out_q;
    if (sel_mem_q) begin
      out_data_o.out_version  = rd_data.version;
      out_data_o.out_segment  = rd_data.segment;
      out_data_o.out_position = rd_data.position;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.held <= stat.capacity)
    else $error("held count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |->
      out_data_o.out_version == '0 && out_data_o.out_segment == '0 &&
      out_data_o.out_position == '0 && out_data_o.prev_version == '0 &&
      out_data_o.prev_segment == '0 && out_data_o.prev_position == '0)
    else $error("rejected result carries record data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.opcode == OP_CLEAR && !cfg_we_i |=>
      out_valid_o && out_data_o.ok && out_data_o.entry_count == '0 && stat.held == '0)
    else $error("clear did not empty the history");

endmodule

`default_nettype wire

/* hw/rtl/itrb_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module itrb_store import itrb_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 256
) (
  input  wire logic                         clk_i,
  input  wire mem_ctl_t                     ctl_i,
  input  wire logic [$clog2(MAX_DEPTH)-1:0] wr_addr_i,
  input  wire rec_t                         wr_data_i,
  input  wire logic [$clog2(MAX_DEPTH)-1:0] rd_addr_i,
  output rec_t                              rd_data_o
);

  rec_t mem [MAX_DEPTH];
  rec_t rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

/* hw/rtl/itrb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module itrb_ctrl import itrb_pkg::*; #(
  parameter int unsigned MAX_DEPTH        = 256,
  parameter int unsigned EXPECTED_VERSION = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire in_t                          item_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [CountW-1:0]            cfg_wdata_i,
  output out_t                              res_o,
  output logic                              use_mem_o,
  output mem_ctl_t                          mem_ctl_o,
  output logic [$clog2(MAX_DEPTH)-1:0]      wr_addr_o,
  output rec_t                              wr_data_o,
  output logic [$clog2(MAX_DEPTH)-1:0]      rd_addr_o,
  output stat_t                             stat_o
);

  localparam int unsigned AddrW = $clog2(MAX_DEPTH);

  logic [CountW-1:0] cap_q;
  logic [CountW-1:0] wslot_q;
  logic [CountW-1:0] held_q;
  rec_t              last_q;
  logic              last_vld_q;
  rec_t              tprev_q;
  rec_t              tcur_q;
  logic              tvld_q;

  rec_t              rec_in;
  logic              cap_fits;
  logic              rec_ok;
  logic              seg_change;
  logic [CountW:0]   slot_inc;
  logic [CountW-1:0] wslot_nxt;
  logic              held_grow;
  logic [CountW-1:0] oldest;
  logic [CountW:0]   age_sum;
  logic [CountW:0]   rd_slot;
  logic              rd_hit;

  assign rec_in = '{version:  item_i.in_version,
                    segment:  item_i.in_segment,
                    position: item_i.in_position};

  // capacity writes above the store depth are dropped
  assign cap_fits = (32'(cfg_wdata_i) <= 32'(MAX_DEPTH));

  // record admission and ring pointer advance
  assign rec_ok     = (item_i.in_version == 8'(EXPECTED_VERSION)) && (cap_q != '0);
  assign seg_change = last_vld_q && (last_q.segment != item_i.in_segment);
  assign slot_inc   = {1'b0, wslot_q} + {{CountW{1'b0}}, 1'b1};
  assign wslot_nxt  = (slot_inc >= {1'b0, cap_q}) ? '0 : slot_inc[CountW-1:0];
  assign held_grow  = held_q < cap_q;

  // age to slot: oldest entry plus age, wrapped once
  assign oldest  = (held_q == cap_q) ? wslot_q : '0;
  assign age_sum = {1'b0, oldest} + {{(CountW-7){1'b0}}, item_i.age_index};
  assign rd_slot = (age_sum >= {1'b0, cap_q}) ? (age_sum - {1'b0, cap_q}) : age_sum;
  assign rd_hit  = (cap_q != '0) &&
                   ({{(CountW-8){1'b0}}, item_i.age_index} < held_q);

  // store port
  assign wr_addr_o = AddrW'(wslot_q);
  assign wr_data_o = rec_in;
  assign rd_addr_o = AddrW'(rd_slot[CountW-1:0]);
  always_comb begin
    mem_ctl_o.wr_en = accept_i && (item_i.opcode == OP_RECORD) && rec_ok;
    mem_ctl_o.rd_en = accept_i && (item_i.opcode == OP_READ_AGE) && rd_hit;
  end

  // result of the current item
  always_comb begin
    res_o             = '0;
    use_mem_o         = 1'b0;
    res_o.entry_count = held_q;
    case (item_i.opcode)
      OP_RECORD: begin
        res_o.ok = rec_ok;
        if (rec_ok && held_grow) begin
          res_o.entry_count = held_q + CountW'(1);
        end
      end
      OP_READ_AGE: begin
        res_o.ok  = rd_hit;
        use_mem_o = rd_hit;
      end
      OP_READ_TRANS: begin
        if (tvld_q) begin
          res_o.ok            = 1'b1;
          res_o.out_version   = tcur_q.version;
          res_o.out_segment   = tcur_q.segment;
          res_o.out_position  = tcur_q.position;
          res_o.prev_version  = tprev_q.version;
          res_o.prev_segment  = tprev_q.segment;
          res_o.prev_position = tprev_q.position;
        end
      end
      OP_CLEAR: begin
        res_o.ok          = 1'b1;
        res_o.entry_count = '0;
      end
      default: ;
    endcase
  end

  // history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= '0;
      wslot_q    <= '0;
      held_q     <= '0;
      last_q     <= '0;
      last_vld_q <= 1'b0;
      tprev_q    <= '0;
      tcur_q     <= '0;
      tvld_q     <= 1'b0;
    end else if (cfg_we_i) begin
      if (cap_fits) begin
        cap_q      <= cfg_wdata_i;
        wslot_q    <= '0;
        held_q     <= '0;
        last_q     <= '0;
        last_vld_q <= 1'b0;
        tprev_q    <= '0;
        tcur_q     <= '0;
        tvld_q     <= 1'b0;
      end
    end else if (accept_i) begin
      case (item_i.opcode)
        OP_RECORD: begin
          if (rec_ok) begin
            if (seg_change) begin
              tprev_q <= last_q;
              tcur_q  <= rec_in;
              tvld_q  <= 1'b1;
            end
            last_q     <= rec_in;
            last_vld_q <= 1'b1;
            wslot_q    <= wslot_nxt;
            if (held_grow) begin
              held_q <= held_q + CountW'(1);
            end
          end
        end
        OP_CLEAR: begin
          wslot_q    <= '0;
          held_q     <= '0;
          last_q     <= '0;
          last_vld_q <= 1'b0;
          tprev_q    <= '0;
          tcur_q     <= '0;
          tvld_q     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o = '{capacity: cap_q, held: held_q};

endmodule

`default_nettype wire

/* test/tb_instruction_trace_ring_buffer.sv */
`timescale 1ns / 1ps

module tb_instruction_trace_ring_buffer import itrb_pkg::*; ();

  localparam int unsigned MaxDepth   = 256;
  localparam logic [7:0]  ExpVersion = 8'd1;

  // one line of the directed plan: either a capacity write or an item
  typedef struct packed {
    logic              is_cfg;
    logic [CountW-1:0] cfg_val;
    in_t               item;
    logic              pinned;
    out_t              want;
  } plan_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_we    = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;

  // typed-in expectation that travels with the driven item
  logic in_pinned     = 1'b0;
  out_t in_pinned_res = '0;

  logic        calm           = 1'b0;
  int unsigned mismatch_count = 0;
  out_t        pending_results[$];
  plan_row_t   plan[$];

  // trace buffer model state
  rec_t        trace_mem [MaxDepth];
  int unsigned cap_model;
  int unsigned slot_model;
  int unsigned held_model;
  rec_t        last_rec;
  logic        last_rec_ok;
  rec_t        trans_prev;
  rec_t        trans_cur;
  logic        trans_ok;
  logic [15:0] cur_seg = 16'h0100;

  instruction_trace_ring_buffer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  // model: drop history and transition
  function automatic void clear_trace_model();
    slot_model  = 0;
    held_model  = 0;
    last_rec    = '0;
    last_rec_ok = 1'b0;
    trans_prev  = '0;
    trans_cur   = '0;
    trans_ok    = 1'b0;
  endfunction

  // model: capacity write, oversized values are ignored
  function automatic void set_capacity_model(input logic [CountW-1:0] val);
    if (32'(val) <= MaxDepth) begin
      cap_model = 32'(val);
      clear_trace_model();
    end
  endfunction

  // model: apply one item and return the result it produces
  function automatic out_t predict_result(input in_t it);
    rec_t        r;
    out_t        res;
    int unsigned oldest;
    int unsigned slot;
    res        = '0;
    r.version  = it.in_version;
    r.segment  = it.in_segment;
    r.position = it.in_position;
    case (it.opcode)
      OP_RECORD: begin
        if (r.version == ExpVersion && cap_model != 0) begin
          if (last_rec_ok && last_rec.segment != r.segment) begin
            trans_prev = last_rec;
            trans_cur  = r;
            trans_ok   = 1'b1;
          end
          last_rec    = r;
          last_rec_ok = 1'b1;
          trace_mem[slot_model] = r;
          slot_model = (slot_model + 1 >= cap_model) ? 0 : slot_model + 1;
          if (held_model < cap_model) held_model++;
          res.ok = 1'b1;
        end
      end
      OP_READ_AGE: begin
        if (cap_model != 0 && 32'(it.age_index) < held_model) begin
          oldest = (held_model == cap_model) ? slot_model : 0;
          slot   = oldest + 32'(it.age_index);
          if (slot >= cap_model) slot -= cap_model;
          res.out_version  = trace_mem[slot].version;
          res.out_segment  = trace_mem[slot].segment;
          res.out_position = trace_mem[slot].position;
          res.ok = 1'b1;
        end
      end
      OP_READ_TRANS: begin
        if (trans_ok) begin
          res.out_version   = trans_cur.version;
          res.out_segment   = trans_cur.segment;
          res.out_position  = trans_cur.position;
          res.prev_version  = trans_prev.version;
          res.prev_segment  = trans_prev.segment;
          res.prev_position = trans_prev.position;
          res.ok = 1'b1;
        end
      end
      default: begin
        clear_trace_model();
        res.ok = 1'b1;
      end
    endcase
    res.entry_count = held_model[CountW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic compare_result(input out_t got, input out_t want);
    if (got.ok !== want.ok) report_mismatch("ok", 32'(got.ok), 32'(want.ok));
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    if (got.out_version !== want.out_version)
      report_mismatch("out_version", 32'(got.out_version), 32'(want.out_version));
    if (got.out_segment !== want.out_segment)
      report_mismatch("out_segment", 32'(got.out_segment), 32'(want.out_segment));
    if (got.out_position !== want.out_position)
      report_mismatch("out_position", got.out_position, want.out_position);
    if (got.prev_version !== want.prev_version)
      report_mismatch("prev_version", 32'(got.prev_version), 32'(want.prev_version));
    if (got.prev_segment !== want.prev_segment)
      report_mismatch("prev_segment", 32'(got.prev_segment), 32'(want.prev_segment));
    if (got.prev_position !== want.prev_position)
      report_mismatch("prev_position", got.prev_position, want.prev_position);
  endtask

  // transfer monitor: check results, predict accepted items, track capacity writes
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(out_data.entry_count), '0);
        end else begin
          want = pending_results.pop_front();
          compare_result(out_data, want);
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_result(in_data);
        if (in_pinned) want = in_pinned_res;
        pending_results.push_back(want);
      end
      if (cfg_we) set_capacity_model(cfg_wdata);
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 30);
  end

  function automatic in_t mk_item(input op_e op, input logic [7:0] v, input logic [15:0] s,
                                  input logic [31:0] p, input logic [7:0] a);
    in_t it;
    it.opcode      = op;
    it.in_version  = v;
    it.in_segment  = s;
    it.in_position = p;
    it.age_index   = a;
    return it;
  endfunction

  function automatic out_t mk_res(input logic ok, input logic [CountW-1:0] cnt,
                                  input logic [7:0] ov, input logic [15:0] os,
                                  input logic [31:0] op, input logic [7:0] pv,
                                  input logic [15:0] ps, input logic [31:0] pp);
    out_t res;
    res.ok            = ok;
    res.entry_count   = cnt;
    res.out_version   = ov;
    res.out_segment   = os;
    res.out_position  = op;
    res.prev_version  = pv;
    res.prev_segment  = ps;
    res.prev_position = pp;
    return res;
  endfunction

  function automatic void add_row(input in_t it, input logic pin, input out_t want);
    plan_row_t row;
    row        = '0;
    row.item   = it;
    row.pinned = pin;
    row.want   = want;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CountW-1:0] val);
    plan_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = val;
    plan.push_back(row);
  endfunction

  // random item, mostly well-formed records and in-range reads
  function automatic in_t random_item();
    in_t         it;
    int unsigned pick;
    int unsigned bound;
    pick  = $urandom_range(0, 99);
    bound = (held_model + 1 > 255) ? 255 : held_model + 1;
    if ($urandom_range(0, 3) == 0) cur_seg = 16'($urandom);
    if (pick < 55)      it.opcode = OP_RECORD;
    else if (pick < 85) it.opcode = OP_READ_AGE;
    else if (pick < 97) it.opcode = OP_READ_TRANS;
    else                it.opcode = OP_CLEAR;
    it.in_version  = ($urandom_range(0, 9) < 8) ? ExpVersion : 8'($urandom_range(0, 255));
    it.in_segment  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_seg;
    it.in_position = $urandom;
    it.age_index   = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, bound))
                                                  : 8'($urandom_range(0, 255));
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input in_t it, input logic pin, input out_t want);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data       <= it;
    in_pinned     <= pin;
    in_pinned_res <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every pending result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CountW-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase_cap [8];
    int unsigned phase_len [8];
    int unsigned i;
    int unsigned n;
    out_t        none;

    for (i = 0; i < MaxDepth; i++) trace_mem[i] = '0;
    cap_model = 0;
    clear_trace_model();
    none = mk_res(1'b0, 9'd0, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 32'd0);

    // directed plan: capacity zero first, then a two-entry ring, then edge writes
    add_row(mk_item(OP_RECORD, ExpVersion, 16'h1234, 32'h0000_0001, 8'd0), 1'b1, none);
    add_row(mk_item(OP_READ_AGE, 8'd0, 16'd0, 32'd0, 8'd0), 1'b1, none);
    add_row(mk_item(OP_READ_TRANS, 8'd0, 16'd0, 32'd0, 8'd0), 1'b1, none);
    add_row(mk_item(OP_CLEAR, 8'hff, 16'hffff, 32'hffff_ffff, 8'hff), 1'b1,
            mk_res(1'b1, 9'd0, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 32'd0));
    add_cfg(9'd2);
    add_row(mk_item(OP_RECORD, 8'd0, 16'hffff, 32'hffff_ffff, 8'd0), 1'b1, none);
    add_row(mk_item(OP_RECORD, 8'hff, 16'h0000, 32'h0000_0000, 8'hff), 1'b1, none);
    add_row(mk_item(OP_RECORD, ExpVersion, 16'h0000, 32'h0000_0000, 8'd0), 1'b1,
            mk_res(1'b1, 9'd1, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 32'd0));
    add_row(mk_item(OP_RECORD, ExpVersion, 16'hffff, 32'hffff_ffff, 8'd0), 1'b1,
            mk_res(1'b1, 9'd2, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 32'd0));
    add_row(mk_item(OP_READ_TRANS, 8'd0, 16'd0, 32'd0, 8'd0), 1'b1,
            mk_res(1'b1, 9'd2, ExpVersion, 16'hffff, 32'hffff_ffff,
                   ExpVersion, 16'h0000, 32'h0000_0000));
    add_row(mk_item(OP_RECORD, ExpVersion, 16'hffff, 32'h1234_5678, 8'd0), 1'b1,
            mk_res(1'b1, 9'd2, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 32'd0));
    add_row(mk_item(OP_READ_AGE, 8'd0, 16'd0, 32'd0, 8'd0), 1'b0, '0);
    add_row(mk_item(OP_READ_AGE, 8'd0, 16'd0, 32'd0, 8'd1), 1'b0, '0);
    add_row(mk_item(OP_READ_AGE, 8'd0, 16'd0, 32'd0, 8'd2), 1'b1,
            mk_res(1'b0, 9'd2, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 32'd0));
    add_row(mk_item(OP_READ_AGE, 8'd0, 16'd0, 32'd0, 8'hff), 1'b1,
            mk_res(1'b0, 9'd2, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 32'd0));
    // oversized capacity writes leave the history alone
    add_cfg(9'd300);
    add_row(mk_item(OP_READ_AGE, 8'd0, 16'd0, 32'd0, 8'd1), 1'b0, '0);
    add_cfg(9'h1ff);
    add_row(mk_item(OP_READ_TRANS, 8'd0, 16'd0, 32'd0, 8'd0), 1'b0, '0);
    add_row(mk_item(OP_CLEAR, 8'd0, 16'd0, 32'd0, 8'd0), 1'b1,
            mk_res(1'b1, 9'd0, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, 32'd0));
    add_row(mk_item(OP_READ_TRANS, 8'd0, 16'd0, 32'd0, 8'd0), 1'b1, none);
    add_cfg(9'd256);
    add_row(mk_item(OP_RECORD, ExpVersion, 16'h0005, 32'haaaa_5555, 8'd0), 1'b0, '0);
    add_row(mk_item(OP_READ_AGE, 8'd0, 16'd0, 32'd0, 8'd0), 1'b0, '0);
    // single-entry ring still latches a transition
    add_cfg(9'd1);
    add_row(mk_item(OP_RECORD, ExpVersion, 16'h0007, 32'h5555_aaaa, 8'd0), 1'b0, '0);
    add_row(mk_item(OP_RECORD, ExpVersion, 16'h0008, 32'h0f0f_f0f0, 8'd0), 1'b0, '0);
    add_row(mk_item(OP_READ_TRANS, 8'd0, 16'd0, 32'd0, 8'd0), 1'b0, '0);
    add_row(mk_item(OP_READ_AGE, 8'd0, 16'd0, 32'd0, 8'd0), 1'b0, '0);

    phase_cap = '{1, 2, 3, 7, 0, 256, 0, 0};
    phase_len = '{100, 100, 100, 150, 150, 500, 100, 60};
    phase_cap[4] = $urandom_range(4, 255);
    phase_cap[6] = $urandom_range(257, 511);

    // reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_capacity(plan[k].cfg_val);
      else send_item(plan[k].item, plan[k].pinned, plan[k].want);
    end

    // random phases, one capacity setting each
    for (i = 0; i < 8; i++) begin
      write_capacity(phase_cap[i][CountW-1:0]);
      calm = (i == 3);
      for (n = 0; n < phase_len[i]; n++) begin
        if (i == 5 && n == 250) wait_drained();
        send_item(random_item(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    // drain
    in_valid <= 1'b0;
    for (n = 0; n < 10000 && pending_results.size() != 0; n++) @(negedge clk);
    repeat (5) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", pending_results.size(), '0);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
